// ----- hw/rtl/mios_pkg.sv -----
// ----------------------------------------------------------------------------
// mios_pkg: shared types and constants for the interval overlap sweep
// Sizes of the interval stores, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package mios_pkg;

  localparam int MaxItems  = 256;
  localparam int TimeBits  = 16;
  localparam int AddrBits  = $clog2(MaxItems);
  localparam int CountBits = AddrBits + 1;

  typedef logic [TimeBits-1:0]  time_t;
  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [CountBits-1:0] count_t;
  // running overlap count of the merge, may go below zero
  typedef logic signed [CountBits+1:0] run_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD_A,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_SW_RD,
    ST_SW_CMP,
    ST_DONE
  } state_t;

  // port of one sort store toward the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    time_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

// ----- hw/rtl/mios_store.sv -----
// ----------------------------------------------------------------------------
// mios_store: interval time store
// One write port and one registered read port over the held times.
// ----------------------------------------------------------------------------
module mios_store (
  input  logic              clk,
  input  mios_pkg::mem_req_t req,
  output mios_pkg::time_t   rdata
);

  mios_pkg::time_t mem [mios_pkg::MaxItems];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hw/rtl/max_interval_overlap_sweep.sv -----
// ----------------------------------------------------------------------------
// max_interval_overlap_sweep: peak overlap of a set of closed intervals
// Loads intervals, sorts both endpoint lists, merges them to find the peak.
// ----------------------------------------------------------------------------
// Each accepted request is stored while the store has room; requests past
// MaxItems are dropped and flagged on out_overflow. On the last request the
// block insertion-sorts the arrival and departure lists one after the other
// through the single read and write port of each store: it reads each key,
// then compares and shifts neighbours one step at a time. Then it merges the
// lists, comparing the heads of the two lists at each step. in_stall stays
// high from the last request until the result is taken.
module max_interval_overlap_sweep (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_departure_time,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_max_overlap,
  output logic        out_overflow
);

  mios_pkg::state_t state_r, state_nxt;
  mios_pkg::count_t cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             lst_r, lst_nxt;        // 0 arrivals, 1 departures
  mios_pkg::count_t ia_r, ia_nxt;          // outer index / merge arrival index
  mios_pkg::count_t ib_r, ib_nxt;          // shift index / merge departure index
  mios_pkg::time_t  key_r, key_nxt;
  mios_pkg::run_t   run_r, run_nxt;
  mios_pkg::run_t   run_inc;
  mios_pkg::count_t best_r, best_nxt;
  logic [8:0]       res_r, res_nxt;
  logic             ovf_r, ovf_nxt;

  mios_pkg::mem_req_t areq, dreq;
  mios_pkg::time_t    ard, drd;
  mios_pkg::time_t    rd_sel;
  mios_pkg::mem_req_t req;

  logic acc;
  assign acc = in_valid && !in_stall;

  mios_store u_arr (.clk(clk), .req(areq), .rdata(ard));
  mios_store u_dep (.clk(clk), .req(dreq), .rdata(drd));

  assign rd_sel  = lst_r ? drd : ard;
  assign run_inc = run_r + mios_pkg::run_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mios_pkg::ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
    lst_r  <= lst_nxt;
    ia_r   <= ia_nxt;
    ib_r   <= ib_nxt;
    key_r  <= key_nxt;
    run_r  <= run_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
    ovf_r  <= ovf_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mios_pkg::ST_LOAD: begin
        if (acc && in_last_item) begin
          state_nxt = mios_pkg::ST_SORT_RD_A;
        end
      end
      mios_pkg::ST_SORT_RD_A: begin
        if (ia_r >= cnt_r) begin
          state_nxt = lst_r ? mios_pkg::ST_SW_RD : mios_pkg::ST_SORT_RD_A;
        end else begin
          state_nxt = mios_pkg::ST_SORT_CMP;
        end
      end
      mios_pkg::ST_SORT_CMP: state_nxt = mios_pkg::ST_SORT_WR;
      mios_pkg::ST_SORT_WR: begin
        if (ib_r == '0 || !(rd_sel > key_r)) begin
          state_nxt = mios_pkg::ST_SORT_RD_A;
        end else begin
          state_nxt = mios_pkg::ST_SORT_CMP;
        end
      end
      mios_pkg::ST_SW_RD: begin
        if (cnt_r == '0 || ia_r >= cnt_r || ib_r >= cnt_r) begin
          state_nxt = mios_pkg::ST_DONE;
        end else begin
          state_nxt = mios_pkg::ST_SW_CMP;
        end
      end
      mios_pkg::ST_SW_CMP: state_nxt = mios_pkg::ST_SW_RD;
      mios_pkg::ST_DONE: begin
        if (!out_stall) begin
          state_nxt = mios_pkg::ST_LOAD;
        end
      end
      default: state_nxt = mios_pkg::ST_LOAD;
    endcase
  end

  // datapath and store control
  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    lst_nxt  = lst_r;
    ia_nxt   = ia_r;
    ib_nxt   = ib_r;
    key_nxt  = key_r;
    run_nxt  = run_r;
    best_nxt = best_r;
    res_nxt  = res_r;
    ovf_nxt  = ovf_r;
    req.we    = 1'b0;
    req.waddr = ib_r[mios_pkg::AddrBits-1:0];
    req.wdata = key_r;
    req.raddr = ia_r[mios_pkg::AddrBits-1:0];
    areq = '0;
    dreq = '0;
    unique case (state_r)
      mios_pkg::ST_LOAD: begin
        areq.waddr = cnt_r[mios_pkg::AddrBits-1:0];
        areq.wdata = in_arrival_time[mios_pkg::TimeBits-1:0];
        dreq.waddr = cnt_r[mios_pkg::AddrBits-1:0];
        dreq.wdata = in_departure_time[mios_pkg::TimeBits-1:0];
        lst_nxt = 1'b0;
        ia_nxt  = mios_pkg::count_t'(1);
        if (acc) begin
          if (cnt_r < mios_pkg::count_t'(mios_pkg::MaxItems)) begin
            areq.we = 1'b1;
            dreq.we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      mios_pkg::ST_SORT_RD_A: begin
        // fetch key v[ia]
        req.raddr = ia_r[mios_pkg::AddrBits-1:0];
        key_nxt = rd_sel;
        if (ia_r >= cnt_r) begin
          lst_nxt = 1'b1;
          ia_nxt  = mios_pkg::count_t'(1);
          if (lst_r) begin
            ia_nxt = mios_pkg::count_t'(1);
            ib_nxt = '0;
            run_nxt = mios_pkg::run_t'(1);
            best_nxt = (cnt_r == '0) ? '0 : mios_pkg::count_t'(1);
          end
        end else begin
          ib_nxt = ia_r;
        end
      end
      mios_pkg::ST_SORT_CMP: begin
        // on the first compare the key was read last cycle; read v[ib-1]
        if (ib_r == ia_r) begin
          key_nxt = rd_sel;
        end
        req.raddr = mios_pkg::addr_t'(ib_r - 1'b1);
      end
      mios_pkg::ST_SORT_WR: begin
        if (ib_r != '0 && rd_sel > key_r) begin
          req.we    = 1'b1;
          req.wdata = rd_sel;
          ib_nxt    = ib_r - 1'b1;
        end else begin
          req.we = 1'b1;
          ia_nxt = ia_r + 1'b1;
        end
      end
      mios_pkg::ST_SW_RD: begin
        areq.raddr = ia_r[mios_pkg::AddrBits-1:0];
        dreq.raddr = ib_r[mios_pkg::AddrBits-1:0];
        res_nxt = (best_r > mios_pkg::count_t'(511)) ? 9'd511 : 9'(best_r);
        ovf_nxt = drop_r;
      end
      mios_pkg::ST_SW_CMP: begin
        areq.raddr = ia_r[mios_pkg::AddrBits-1:0];
        dreq.raddr = ib_r[mios_pkg::AddrBits-1:0];
        if (ard <= drd) begin
          run_nxt = run_inc;
          ia_nxt  = ia_r + 1'b1;
          if (run_inc > mios_pkg::run_t'({2'b00, best_r})) begin
            best_nxt = mios_pkg::count_t'(run_inc);
          end
        end else begin
          run_nxt = run_r - mios_pkg::run_t'(1);
          ib_nxt  = ib_r + 1'b1;
        end
      end
      mios_pkg::ST_DONE: begin
        if (!out_stall) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    if (state_r != mios_pkg::ST_LOAD && state_r != mios_pkg::ST_SW_RD &&
        state_r != mios_pkg::ST_SW_CMP) begin
      if (lst_r) dreq = req;
      else       areq = req;
    end
  end

  // outputs
  always_comb begin
    in_stall        = (state_r != mios_pkg::ST_LOAD);
    out_valid       = (state_r == mios_pkg::ST_DONE);
    out_max_overlap = res_r;
    out_overflow    = ovf_r;
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("result shown while loading");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mios_pkg::count_t'(mios_pkg::MaxItems)) else $error("count past capacity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_overlap))
    else $error("result lost under stall");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> cnt_r == '0 && !drop_r)
    else $error("set not cleared after result");

endmodule

// ----- test/max_interval_overlap_sweep_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_interval_overlap_sweep_test: self-checking bench for the overlap sweep
// Sends interval sets with random gaps and stalls and predicts each peak
// overlap and drop flag from its own copy of the interval store.
// ----------------------------------------------------------------------------
module max_interval_overlap_sweep_test;

  class overlap_scoreboard;
    mios_pkg::time_t arr_q[$];
    mios_pkg::time_t dep_q[$];
    bit    dropped;
    logic [8:0] peak_q[$];
    bit         flag_q[$];
    int errors;
    int checked;

    function logic [8:0] peak_of();
      mios_pkg::time_t a[$];
      mios_pkg::time_t d[$];
      int ia, id, cnt, best, n;
      a = arr_q;
      d = dep_q;
      n = a.size();
      if (n == 0) return 0;
      a.sort();
      d.sort();
      ia = 1; id = 0; cnt = 1; best = 1;
      while (ia < n && id < n) begin
        if (a[ia] <= d[id]) begin
          cnt++;
          ia++;
        end else begin
          cnt--;
          id++;
        end
        if (cnt > best) best = cnt;
      end
      if (best > 511) best = 511;
      return best[8:0];
    endfunction

    function void note_request(mios_pkg::time_t arr, mios_pkg::time_t dep, bit last);
      if (arr_q.size() < mios_pkg::MaxItems) begin
        arr_q.push_back(arr);
        dep_q.push_back(dep);
      end else begin
        dropped = 1;
      end
      if (last) begin
        peak_q.push_back(peak_of());
        flag_q.push_back(dropped);
        arr_q = {};
        dep_q = {};
        dropped = 0;
      end
    endfunction

    function void check_result(logic [8:0] peak, logic flag);
      checked++;
      if (peak_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result peak=%0d flag=%0d", peak, flag);
      end else begin
        logic [8:0] ep;
        bit ef;
        ep = peak_q.pop_front();
        ef = flag_q.pop_front();
        if (peak !== ep || flag !== ef) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: peak exp %0d got %0d, overflow exp %0d got %0d",
                     ep, peak, ef, flag);
        end
      end
    endfunction

    function int pending();
      return peak_q.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] in_arrival_time = 0;
  logic [15:0] in_departure_time = 0;
  logic in_last_item = 0;
  logic out_valid;
  logic out_stall = 1;
  logic [8:0] out_max_overlap;
  logic out_overflow;

  overlap_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int sets = 0;
  bit hold_long = 0;
  bit rx_random = 1;
  localparam int CycleLimit = 4000000;

  always #4 clk = ~clk;

  max_interval_overlap_sweep dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("max_interval_overlap_sweep_test: done, errors");
      $finish;
    end
  end

  // result side: accept, check, and draw a stall length per result
  initial begin : receiver
    int wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end
      wait_n = rx_random ? $urandom_range(0, 15) : 0;
      if (wait_n > 0) begin
        out_stall <= 1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_max_overlap, out_overflow);
    end
  end

  task automatic send_request(input mios_pkg::time_t arr, input mios_pkg::time_t dep,
                              input bit last, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_arrival_time <= arr;
    in_departure_time <= dep;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(arr, dep, last);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one set of random intervals; mostly short ones clustered in a narrow window
  task automatic send_set(input int n, input bit no_gap);
    mios_pkg::time_t a, d;
    int span;
    span = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(4, 200);
    for (int k = 0; k < n; k++) begin
      a = mios_pkg::time_t'($urandom_range(0, span));
      d = $urandom_range(0, 7) == 0 ? mios_pkg::time_t'($urandom_range(0, 65535))
                                    : mios_pkg::time_t'(a + $urandom_range(0, 40));
      send_request(a, d, k == n - 1, no_gap);
    end
    sets++;
  endtask

  initial begin : sender
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: single interval, extremes, touching endpoints, reversed interval
    send_request(16'h0000, 16'hffff, 1, 0);
    send_request(16'hffff, 16'h0000, 1, 0);
    send_request(16'd10, 16'd20, 0, 0);
    send_request(16'd20, 16'd30, 1, 0);
    send_request(16'd10, 16'd20, 0, 0);
    send_request(16'd21, 16'd30, 1, 0);
    send_request(16'hffff, 16'hffff, 0, 0);
    send_request(16'hffff, 16'hffff, 0, 0);
    send_request(16'h0000, 16'h0000, 1, 0);
    send_request(16'h5555, 16'haaaa, 0, 0);
    send_request(16'haaaa, 16'h5555, 0, 0);
    send_request(16'h0001, 16'hfffe, 1, 0);
    wait_drained();
    // store full: 257 items then last, 258 items total; sorted input keeps it short
    for (int k = 0; k < 258; k++)
      send_request(k[15:0], k[15:0] + 16'd3, k == 257, 1);
    sets++;
    wait_drained();
    // exactly full, last item stored
    for (int k = 0; k < mios_pkg::MaxItems; k++)
      send_request(16'd100, 16'd100, k == mios_pkg::MaxItems - 1, 1);
    sets++;
    wait_drained();
    // receiver holds off while sender keeps offering sets
    hold_long = 1;
    for (int s = 0; s < 6; s++) send_set($urandom_range(1, 4), 1);
    wait_drained();
    rx_random = 0;
    for (int s = 0; s < 8; s++) send_set($urandom_range(1, 6), 1);
    rx_random = 1;
    while (sent < 600) send_set($urandom_range(0, 9) == 0 ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 8), 0);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("sent %0d requests in %0d sets, %0d results checked", sent, sets, sb.checked);
    $display("covered full and overflowing stores, touching and reversed intervals");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("max_interval_overlap_sweep_test: done, clean");
    else
      $display("max_interval_overlap_sweep_test: done, errors");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/mios_pkg.sv
hw/rtl/mios_store.sv
hw/rtl/max_interval_overlap_sweep.sv
test/max_interval_overlap_sweep_test.sv
